@@ rtl/core/rc_pulse_capture_and_scale_core_macros.svh @@
// ----------------------------------------------------------------------------
// RC pulse capture and scale core: assertion macros
// Shared forms for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_CAPTURE_AND_SCALE_CORE_MACROS_SVH
`define RC_PULSE_CAPTURE_AND_SCALE_CORE_MACROS_SVH

// same-cycle implication
`define RCPCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RCPCS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/rcpcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpcs_pkg
// Widths, constants, shared types and scaling helpers of the RC pulse
// capture and scale core.
// ----------------------------------------------------------------------------
package rcpcs_pkg;

   // channel layout
   localparam int NUM_CHANNELS_DEF = 5;
   localparam int MAX_LANES        = 5;
   localparam int CH_W             = 3;

   // field widths
   localparam int STAMP_W     = 32;
   localparam int WIDTH_W     = 16;
   localparam int STICK_W     = 11;
   localparam int CAL_W       = 49;
   localparam int CSR_IDX_W   = 3;
   localparam int QUOT_W      = 9;
   localparam int NUM_W       = WIDTH_W + QUOT_W;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 64;

   // stick scale
   localparam logic [STICK_W-1:0] STICK_MID  = 11'd1500;
   localparam logic [STICK_W-1:0] STICK_MIN  = 11'd1000;
   localparam logic [STICK_W-1:0] STICK_MAX  = 11'd2000;
   localparam logic [QUOT_W-1:0]  STICK_SPAN = 9'd500;

   // calibration after reset: low 1000, high 2000, center 1500, not reversed
   localparam logic [CAL_W-1:0] CAL_RESET = {1'b0, 16'd1500, 16'd2000, 16'd1000};

   localparam logic [WIDTH_W-1:0] WIDTH_SAT = '1;

   // divider request and answer
   typedef struct packed {
      logic               start;
      logic [NUM_W-1:0]   num;
      logic [WIDTH_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

   // per-channel setup ahead of the division
   typedef struct packed {
      logic               needed;
      logic               add;
      logic [NUM_W-1:0]   num;
      logic [WIDTH_W-1:0] den;
   } scale_setup_type;

   // clamp width, pick side, form numerator (offset * 500) and divisor
   function automatic scale_setup_type scale_setup(input logic [WIDTH_W-1:0] width,
                                                   input logic [CAL_W-1:0]   cal);
      logic [WIDTH_W-1:0] lo;
      logic [WIDTH_W-1:0] hi;
      logic [WIDTH_W-1:0] ctr;
      logic [WIDTH_W-1:0] wc;
      logic [WIDTH_W-1:0] mag;
      logic               rev;
      scale_setup_type    s;
      lo  = cal[15:0];
      hi  = cal[31:16];
      ctr = cal[47:32];
      rev = cal[48];
      s   = '0;
      if (width < ctr) begin
         wc       = (width < lo) ? lo : width;
         s.needed = (ctr > lo);
         s.den    = ctr - lo;
         mag      = ctr - wc;
         s.add    = rev;
      end else begin
         wc       = (width > hi) ? hi : width;
         s.needed = (width != ctr) && (hi > ctr);
         s.den    = hi - ctr;
         mag      = wc - ctr;
         s.add    = !rev;
      end
      s.num = {{QUOT_W{1'b0}}, mag} * {{WIDTH_W{1'b0}}, STICK_SPAN};
      return s;
   endfunction

   // apply the offset around center and saturate
   function automatic logic [STICK_W-1:0] scale_finish(input logic              add,
                                                       input logic [QUOT_W-1:0] q);
      logic [STICK_W:0] r;
      r = add ? ({1'b0, STICK_MID} + {{(STICK_W+1-QUOT_W){1'b0}}, q})
              : ({1'b0, STICK_MID} - {{(STICK_W+1-QUOT_W){1'b0}}, q});
      if (r < {1'b0, STICK_MIN}) begin
         r = {1'b0, STICK_MIN};
      end
      if (r > {1'b0, STICK_MAX}) begin
         r = {1'b0, STICK_MAX};
      end
      return r[STICK_W-1:0];
   endfunction

endpackage

@@ rtl/core/rcpcs_capture.sv @@
// ----------------------------------------------------------------------------
// rcpcs_capture
// Edge detection on the receiver pins, rise time stamps and saturated
// pulse widths per channel, plus the update mask of the last item.
// ----------------------------------------------------------------------------
module rcpcs_capture #(
   parameter int LANES = rcpcs_pkg::MAX_LANES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                take,
   input  logic [rcpcs_pkg::MAX_LANES-1:0]     pins,
   input  logic [rcpcs_pkg::STAMP_W-1:0]       now,
   input  logic [rcpcs_pkg::CH_W-1:0]          sel,
   output logic [rcpcs_pkg::WIDTH_W-1:0]       rd_width,
   output logic [rcpcs_pkg::MAX_LANES-1:0]     mask
);

   localparam int SEL_W = (LANES > 1) ? $clog2(LANES) : 1;

   logic                              prior_ff [LANES];
   logic [rcpcs_pkg::STAMP_W-1:0]     stamp_ff [LANES];
   logic [rcpcs_pkg::WIDTH_W-1:0]     width_ff [LANES];
   logic [rcpcs_pkg::WIDTH_W-1:0]     width_in [LANES];
   logic [rcpcs_pkg::MAX_LANES-1:0]   mask_ff;
   logic [rcpcs_pkg::MAX_LANES-1:0]   mask_in;
   logic [rcpcs_pkg::STAMP_W-1:0]     dt;

   // falling edges end a pulse: width is now minus rise stamp, saturated
   always_comb begin
      mask_in = '0;
      dt      = '0;
      for (int k = 0; k < LANES; k++) begin
         mask_in[k]  = !pins[k] && prior_ff[k];
         dt          = now - stamp_ff[k];
         width_in[k] = (dt[rcpcs_pkg::STAMP_W-1:rcpcs_pkg::WIDTH_W] != '0)
                       ? rcpcs_pkg::WIDTH_SAT : dt[rcpcs_pkg::WIDTH_W-1:0];
      end
   end

   // per-channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LANES; k++) begin
            prior_ff[k] <= 1'b0;
            stamp_ff[k] <= '0;
            width_ff[k] <= '0;
         end
         mask_ff <= '0;
      end else if (take) begin
         for (int k = 0; k < LANES; k++) begin
            if (pins[k] && !prior_ff[k]) begin
               prior_ff[k] <= 1'b1;
               stamp_ff[k] <= now;
            end else if (mask_in[k]) begin
               prior_ff[k] <= 1'b0;
               width_ff[k] <= width_in[k];
            end
         end
         mask_ff <= mask_in;
      end
   end

   // width read port for the sequencer
   always_comb begin
      rd_width = '0;
      if (sel < rcpcs_pkg::CH_W'(LANES)) begin
         rd_width = width_ff[sel[SEL_W-1:0]];
      end
   end

   assign mask = mask_ff;

endmodule

@@ rtl/core/rcpcs_div.sv @@
// ----------------------------------------------------------------------------
// rcpcs_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in QUOT_W bits (numerator below divisor * 2^QUOT_W).
// ----------------------------------------------------------------------------
module rcpcs_div (
   input  logic                    clock,
   input  logic                    reset,
   input  rcpcs_pkg::div_req_type  req,
   output rcpcs_pkg::div_rsp_type  rsp
);

   localparam int CNT_W = $clog2(rcpcs_pkg::QUOT_W + 1);

   logic [rcpcs_pkg::NUM_W-1:0]  rem_ff;
   logic [rcpcs_pkg::NUM_W-1:0]  dsh_ff;
   logic [rcpcs_pkg::QUOT_W-1:0] quot_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         busy_ff;
   logic                         done_ff;
   logic [rcpcs_pkg::NUM_W:0]    trial;
   logic                         fits;

   // trial subtraction of the shifted divisor
   assign trial = {1'b0, rem_ff} - {1'b0, dsh_ff};
   assign fits  = !trial[rcpcs_pkg::NUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         rem_ff  <= req.num;
         dsh_ff  <= {1'b0, req.den, {(rcpcs_pkg::QUOT_W-1){1'b0}}};
         quot_ff <= '0;
         cnt_ff  <= CNT_W'(rcpcs_pkg::QUOT_W);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= trial[rcpcs_pkg::NUM_W-1:0];
         end
         quot_ff <= {quot_ff[rcpcs_pkg::QUOT_W-2:0], fits};
         dsh_ff  <= dsh_ff >> 1;
         cnt_ff  <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

@@ rtl/core/rc_pulse_capture_and_scale_core.sv @@
// ----------------------------------------------------------------------------
// rc_pulse_capture_and_scale_core
// RC receiver pulse-width decoder with calibrated stick scaling.
// ----------------------------------------------------------------------------
// Each accepted item updates the pulse capture of the receiver channels and
// then scales the five stored widths one channel after the other through a
// single shared serial divider (nine quotient steps). A channel that needs a
// division passes through S_SETUP and S_DIV, one that does not is settled in
// S_SETUP alone. req_tready is low from acceptance until the result is loaded
// into the output register, so no new item is taken while one is in work. The
// result sits in an output register, so the core accepts the next item while
// an earlier result waits for rsp_tready, and only holds off finishing an item
// until that register is free. Calibration writes are taken at any time and
// belong while the core is idle. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module rc_pulse_capture_and_scale_core #(
   parameter int NUM_CHANNELS = rcpcs_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input item
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rcpcs_pkg::REQ_TDATA_W-1:0]     req_tdata,  // pin_levels[4:0], time_us[36:5]
   // result item
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rcpcs_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // stick_1..stick_5 [54:0],
                                                             // updated_mask[59:55]
   // calibration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rcpcs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rcpcs_pkg::CAL_W-1:0]           csr_data
);

   localparam int LANES = (NUM_CHANNELS < rcpcs_pkg::MAX_LANES) ? NUM_CHANNELS
                                                                : rcpcs_pkg::MAX_LANES;
   localparam int SEL_W = (LANES > 1) ? $clog2(LANES) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SETUP,
      S_DIV,
      S_OUT
   } state_type;

   state_type                            state_ff;
   logic [rcpcs_pkg::CH_W-1:0]           ch_ff;
   logic                                 add_ff;
   logic [rcpcs_pkg::STICK_W-1:0]        sticks_ff [rcpcs_pkg::MAX_LANES];
   logic [rcpcs_pkg::CAL_W-1:0]          cal_ff [LANES];
   logic                                 rsp_tvalid_ff;
   logic [rcpcs_pkg::RSP_TDATA_W-1:0]    rsp_tdata_ff;
   logic [rcpcs_pkg::RSP_TDATA_W-1:0]    rsp_tdata_in;

   logic                                 take;
   logic                                 out_load;
   logic                                 lane_on;
   logic                                 last_ch;
   logic [rcpcs_pkg::CAL_W-1:0]          cal_sel;
   logic [rcpcs_pkg::WIDTH_W-1:0]        cap_width;
   logic [rcpcs_pkg::MAX_LANES-1:0]      cap_mask;
   rcpcs_pkg::scale_setup_type           setup;
   rcpcs_pkg::div_req_type               div_req;
   rcpcs_pkg::div_rsp_type               div_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign take       = req_tvalid && req_tready;
   assign out_load   = (state_ff == S_OUT) && (!rsp_tvalid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // pulse capture
   rcpcs_capture #(
      .LANES (LANES)
   ) u_capture (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .pins     (req_tdata[rcpcs_pkg::MAX_LANES-1:0]),
      .now      (req_tdata[rcpcs_pkg::MAX_LANES +: rcpcs_pkg::STAMP_W]),
      .sel      (ch_ff),
      .rd_width (cap_width),
      .mask     (cap_mask)
   );

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LANES; k++) begin
            cal_ff[k] <= rcpcs_pkg::CAL_RESET;
         end
      end else if (csr_valid && (csr_index < rcpcs_pkg::CSR_IDX_W'(LANES))) begin
         cal_ff[csr_index[SEL_W-1:0]] <= csr_data;
      end
   end

   // setup of the current channel
   assign lane_on = (ch_ff < rcpcs_pkg::CH_W'(LANES));
   assign last_ch = (ch_ff == rcpcs_pkg::CH_W'(rcpcs_pkg::MAX_LANES - 1));
   assign cal_sel = lane_on ? cal_ff[ch_ff[SEL_W-1:0]] : rcpcs_pkg::CAL_RESET;
   assign setup   = rcpcs_pkg::scale_setup(cap_width, cal_sel);

   assign div_req.start = (state_ff == S_SETUP) && lane_on && setup.needed;
   assign div_req.num   = setup.num;
   assign div_req.den   = setup.den;

   // shared divider
   rcpcs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // result packing
   always_comb begin
      rsp_tdata_in = '0;
      for (int k = 0; k < rcpcs_pkg::MAX_LANES; k++) begin
         rsp_tdata_in[k*rcpcs_pkg::STICK_W +: rcpcs_pkg::STICK_W] = sticks_ff[k];
      end
      rsp_tdata_in[rcpcs_pkg::MAX_LANES*rcpcs_pkg::STICK_W +: rcpcs_pkg::MAX_LANES] =
         cap_mask;
   end

   // sequencer over the channels and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ch_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // output valid: load a finished item, or drop the one taken
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (take) begin
                  ch_ff    <= '0;
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               if (div_req.start) begin
                  add_ff   <= setup.add;
                  state_ff <= S_DIV;
               end else begin
                  sticks_ff[ch_ff] <= rcpcs_pkg::STICK_MID;
                  if (last_ch) begin
                     state_ff <= S_OUT;
                  end else begin
                     ch_ff <= ch_ff + 1'b1;
                  end
               end
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  sticks_ff[ch_ff] <= rcpcs_pkg::scale_finish(add_ff, div_rsp.quot);
                  if (last_ch) begin
                     state_ff <= S_OUT;
                  end else begin
                     ch_ff    <= ch_ff + 1'b1;
                     state_ff <= S_SETUP;
                  end
               end
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_tdata_ff <= rsp_tdata_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

@@ rtl/core/rcpcs_checker.sv @@
// ----------------------------------------------------------------------------
// rcpcs_checker
// Port-level checks of the RC pulse capture and scale core, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "rc_pulse_capture_and_scale_core_macros.svh"

module rcpcs_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [rcpcs_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   logic sticks_ok;

   // every stick field within the output scale
   always_comb begin
      sticks_ok = 1'b1;
      for (int k = 0; k < rcpcs_pkg::MAX_LANES; k++) begin
         if ((rsp_tdata[k*rcpcs_pkg::STICK_W +: rcpcs_pkg::STICK_W] < rcpcs_pkg::STICK_MIN) ||
             (rsp_tdata[k*rcpcs_pkg::STICK_W +: rcpcs_pkg::STICK_W] > rcpcs_pkg::STICK_MAX)) begin
            sticks_ok = 1'b0;
         end
      end
   end

   `RCPCS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result item changed")
   `RCPCS_ASSERT_NXT(a_busy_after_take, clock, reset, req_tvalid && req_tready, !req_tready, "item taken while the previous one is in work")
   `RCPCS_ASSERT_NXT(a_no_instant_rsp, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid), "result item right after acceptance")
   `RCPCS_ASSERT_IMP(a_stick_range, clock, reset, rsp_tvalid, sticks_ok, "stick value outside 1000..2000")

endmodule

bind rc_pulse_capture_and_scale_core rcpcs_checker u_rcpcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ verif/tb_rc_pulse_capture_and_scale_core.sv @@
// ----------------------------------------------------------------------------
// tb_rc_pulse_capture_and_scale_core
// Self-checking bench for the RC pulse capture and scale core. A queue-fed
// driver offers pin samples and a monitor checks every result against an
// in-bench decoder. The run steps through several calibration sets and
// several idle and stall patterns, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_rc_pulse_capture_and_scale_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CH      = rcpcs_pkg::NUM_CHANNELS_DEF;
   localparam int LANES       = (NUM_CH < 5) ? NUM_CH : 5;
   localparam int HOLD_CYCLES = 600;
   localparam int SETTLE      = 60;

   // widths and constants of the core
   localparam int STAMP_W     = rcpcs_pkg::STAMP_W;
   localparam int WIDTH_W     = rcpcs_pkg::WIDTH_W;
   localparam int STICK_W     = rcpcs_pkg::STICK_W;
   localparam int CAL_W       = rcpcs_pkg::CAL_W;
   localparam int CSR_IDX_W   = rcpcs_pkg::CSR_IDX_W;
   localparam int REQ_TDATA_W = rcpcs_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = rcpcs_pkg::RSP_TDATA_W;

   localparam logic [STICK_W-1:0]          STICK_MID  = rcpcs_pkg::STICK_MID;
   localparam logic [STICK_W-1:0]          STICK_MIN  = rcpcs_pkg::STICK_MIN;
   localparam logic [STICK_W-1:0]          STICK_MAX  = rcpcs_pkg::STICK_MAX;
   localparam logic [rcpcs_pkg::QUOT_W-1:0] STICK_SPAN = rcpcs_pkg::STICK_SPAN;
   localparam logic [WIDTH_W-1:0]          WIDTH_SAT  = rcpcs_pkg::WIDTH_SAT;
   localparam logic [CAL_W-1:0]            CAL_RESET  = rcpcs_pkg::CAL_RESET;

   // calibration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_CH1, CSR_CAL_CH2, CSR_CAL_CH3, CSR_CAL_CH4, CSR_CAL_CH5
   } cal_reg_type;

   // one input item, packed as on req_tdata (pins in the low bits)
   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [4:0]         pins;
   } sample_type;

   // one result item
   typedef struct packed {
      logic [4:0]             mask;
      logic [4:0][STICK_W-1:0] stick;
   } stick_frame_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index  = CSR_CAL_CH1;
   logic [CAL_W-1:0]         csr_data   = '0;

   // stimulus and expectations
   sample_type       samples_todo[$];
   stick_frame_type  frames_due[$];
   sample_type       offered;
   int               mismatches    = 0;
   int               send_idle_pct = 0;
   int               stall_pct     = 0;
   int               hold_asked    = 0;
   int               hold_served   = 0;
   int               hold_left     = 0;

   // decoder state mirrored in the bench
   logic               level_seen [5] = '{default: 1'b0};
   logic [STAMP_W-1:0] rise_at    [5] = '{default: '0};
   logic [WIDTH_W-1:0] held_width [5] = '{default: '0};
   logic [CAL_W-1:0]   cal_set    [5] = '{default: CAL_RESET};
   logic [CAL_W-1:0]   cal_plan   [5];

   // random pulse-train generator state
   logic [STAMP_W-1:0] gen_stamp = '0;
   logic [4:0]         gen_pins  = '0;

   rc_pulse_capture_and_scale_core #(
      .NUM_CHANNELS(NUM_CH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),   // pin_levels[4:0], time_us[36:5]
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),   // stick_1..stick_5 [54:0], updated_mask[59:55]
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
   endtask

   // width to stick value: clamp, linear map around center, saturate
   function automatic logic [STICK_W-1:0] stick_from_width(
      input logic [WIDTH_W-1:0] width,
      input logic [CAL_W-1:0]   cal
   );
      longint lo;
      longint hi;
      longint ctr;
      longint w;
      longint den;
      longint diff;
      longint res;
      logic   rev;
      lo  = cal[15:0];
      hi  = cal[31:16];
      ctr = cal[47:32];
      rev = cal[48];
      w   = width;
      res = STICK_MID;
      if (w < ctr) begin
         if (w < lo) w = lo;
         den = ctr - lo;
         if (den > 0) begin
            diff = ((ctr - w) * STICK_SPAN) / den;
            res  = rev ? STICK_MID + diff : STICK_MID - diff;
         end
      end else if (w > ctr) begin
         if (w > hi) w = hi;
         den = hi - ctr;
         if (den > 0) begin
            diff = ((w - ctr) * STICK_SPAN) / den;
            res  = rev ? STICK_MID - diff : STICK_MID + diff;
         end
      end
      if (res < STICK_MIN) res = STICK_MIN;
      if (res > STICK_MAX) res = STICK_MAX;
      return res[STICK_W-1:0];
   endfunction

   // edge capture on the pins, then all five scaled widths
   function automatic stick_frame_type decode_sample(input sample_type s);
      stick_frame_type    f;
      logic [STAMP_W-1:0] dt;
      f = '0;
      for (int k = 0; k < LANES; k++) begin
         if (s.pins[k]) begin
            if (!level_seen[k]) begin
               level_seen[k] = 1'b1;
               rise_at[k]    = s.stamp;
            end
         end else if (level_seen[k]) begin
            dt            = s.stamp - rise_at[k];
            level_seen[k] = 1'b0;
            held_width[k] = (dt > 32'h0000_FFFF) ? WIDTH_SAT : dt[WIDTH_W-1:0];
            f.mask[k]     = 1'b1;
         end
      end
      for (int k = 0; k < 5; k++) begin
         f.stick[k] = (k < LANES) ? stick_from_width(held_width[k], cal_set[k]) : STICK_MID;
      end
      return f;
   endfunction

   function automatic logic [CAL_W-1:0] cal_word(input logic [15:0] lo, input logic [15:0] hi,
                                                 input logic [15:0] ctr, input logic rev);
      return {rev, ctr, hi, lo};
   endfunction

   function automatic logic [CAL_W-1:0] cal_typical();
      return cal_word(16'($urandom_range(1150, 900)), 16'($urandom_range(2150, 1850)),
                      16'($urandom_range(1600, 1400)), 1'($urandom_range(1, 0)));
   endfunction

   function automatic void push_sample(input logic [4:0] pins, input logic [STAMP_W-1:0] t);
      sample_type s;
      s.pins  = pins;
      s.stamp = t;
      samples_todo.push_back(s);
   endfunction

   // center width across the time wrap, one width per channel, long pulse
   task automatic queue_directed();
      push_sample(5'h00, 32'h0000_0000);
      push_sample(5'h1F, 32'hFFFF_FF00);
      push_sample(5'h00, 32'h0000_04DC);
      push_sample(5'h1F, 32'd10000);
      push_sample(5'h1E, 32'd10500);
      push_sample(5'h1C, 32'd11000);
      push_sample(5'h18, 32'd11250);
      push_sample(5'h10, 32'd12000);
      push_sample(5'h00, 32'd13000);
      push_sample(5'h1F, 32'd30000);
      push_sample(5'h00, 32'd130000);
      push_sample(5'h1F, 32'hFFFF_FFFF);
      push_sample(5'h15, 32'h0000_07CF);
   endtask

   // mostly pulse trains with rising time, some raw noise
   task automatic queue_random(input int n);
      sample_type s;
      int         r;
      gen_stamp = $urandom;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) begin
            s.pins  = 5'($urandom);
            s.stamp = $urandom;
         end else begin
            r = $urandom_range(99);
            if (r < 90)      gen_stamp += $urandom_range(600, 80);
            else if (r < 95) gen_stamp += $urandom_range(200000, 60000);
            else             gen_stamp += $urandom_range(40, 0);
            for (int k = 0; k < 5; k++) begin
               if ($urandom_range(99) < 25) gen_pins[k] = ~gen_pins[k];
            end
            s.pins  = gen_pins;
            s.stamp = gen_stamp;
         end
         samples_todo.push_back(s);
      end
   endtask

   // wait until every offered item has its result, then let the core settle
   task automatic wait_quiet();
      do @(posedge clock);
      while (samples_todo.size() != 0 || req_tvalid || frames_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write all five calibration registers from cal_plan
   task automatic load_cal();
      for (int k = 0; k < 5; k++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(CSR_CAL_CH1 + k);
         csr_data  <= cal_plan[k];
         do @(posedge clock);
         while (!csr_ready);
         cal_set[k] = cal_plan[k];
      end
      csr_valid <= 1'b0;
   endtask

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            frames_due.push_back(decode_sample(offered));
         end
         if (!req_tvalid || req_tready) begin
            if (samples_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = samples_todo.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_TDATA_W-37){1'b0}}, offered};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result ready: random stalls plus requested long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left   = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      stick_frame_type got;
      stick_frame_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[5*STICK_W+4:0];
         if (frames_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: %h", got));
         end else begin
            want = frames_due.pop_front();
            for (int k = 0; k < 5; k++) begin
               if (got.stick[k] !== want.stick[k]) begin
                  report_mismatch($sformatf("stick_%0d: got %0d, want %0d",
                                            k + 1, got.stick[k], want.stick[k]));
               end
            end
            if (got.mask !== want.mask) begin
               report_mismatch($sformatf("updated_mask: got %b, want %b", got.mask, want.mask));
            end
         end
      end
   end

   // run limit
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // phases
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset calibration, directed pulses, no idling
      queue_directed();
      wait_quiet();

      // reversed and narrow calibrations, directed pulses again
      cal_plan[0] = cal_word(16'd1000, 16'd2000, 16'd1500, 1'b1);
      cal_plan[1] = cal_typical();
      cal_plan[2] = cal_word(16'd1000, 16'd2000, 16'd1500, 1'b1);
      cal_plan[3] = cal_word(16'd1499, 16'd1501, 16'd1500, 1'b0);
      cal_plan[4] = cal_word(16'd900, 16'd2100, 16'd1520, 1'b1);
      load_cal();
      queue_directed();
      wait_quiet();

      // typical calibrations, no idling
      for (int k = 0; k < 5; k++) cal_plan[k] = cal_typical();
      load_cal();
      queue_random(80);
      wait_quiet();

      // arbitrary register contents, sender mostly idle
      for (int k = 0; k < 5; k++) cal_plan[k] = CAL_W'({$urandom, $urandom});
      load_cal();
      send_idle_pct = 88;
      queue_random(80);
      wait_quiet();

      // extremes: zero, all ones, inverted ranges, flat; receiver mostly stalled
      cal_plan[0] = '0;
      cal_plan[1] = '1;
      cal_plan[2] = cal_word(16'd1600, 16'd1400, 16'd1500, 1'b0);
      cal_plan[3] = cal_word(16'd1500, 16'd1500, 16'd1500, 1'b1);
      cal_plan[4] = cal_word(16'd1600, 16'd1400, 16'd1500, 1'b1);
      load_cal();
      send_idle_pct = 0;
      stall_pct     = 88;
      queue_random(80);
      wait_quiet();

      // both sides idle now and then, with one long output hold-off
      for (int k = 0; k < 5; k++) cal_plan[k] = cal_typical();
      load_cal();
      send_idle_pct = 23;
      stall_pct     = 23;
      queue_random(80);
      hold_asked++;
      wait_quiet();

      // tight ranges, no idling
      for (int k = 0; k < 5; k++) begin
         cal_plan[k] = cal_word(16'd1490, 16'd1510, 16'd1500, 1'($urandom_range(1, 0)));
      end
      load_cal();
      send_idle_pct = 0;
      stall_pct     = 0;
      queue_random(80);
      wait_quiet();

      if (frames_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", frames_due.size()));
      end
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
